// ===== rtl/tcm_pkg.sv =====
//------------------------------------------------------------------------------
// tcm_pkg
// Shared types and constants of the two-wire command master.
//------------------------------------------------------------------------------
`default_nettype none

package tcm_pkg;

	localparam int unsigned CfgAddrWidth = 4;
	localparam int unsigned CfgDataWidth = 32;

	localparam logic [1:0] REG_DEVICE_ADDRESS   = 2'd0;
	localparam logic [1:0] REG_ADDRESS_MASK     = 2'd1;
	localparam logic [1:0] REG_KEY_READ_COMMAND = 2'd2;
	localparam logic [1:0] REG_ACK_RETRY_LIMIT  = 2'd3;

	localparam logic [7:0]  RST_DEVICE_ADDRESS   = 8'd64;
	localparam logic [7:0]  RST_ADDRESS_MASK     = 8'd62;
	localparam logic [15:0] RST_KEY_READ_COMMAND = 16'd1792;
	localparam logic [7:0]  RST_ACK_RETRY_LIMIT  = 8'd20;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef enum logic [13:0] {
		PH_IDLE   = 14'b00000000000001,
		PH_ST_A   = 14'b00000000000010,
		PH_ST_B   = 14'b00000000000100,
		PH_ST_C   = 14'b00000000001000,
		PH_TX_LO  = 14'b00000000010000,
		PH_TX_HI  = 14'b00000000100000,
		PH_ACK_LO = 14'b00000001000000,
		PH_ACK_HI = 14'b00000010000000,
		PH_RX_LO  = 14'b00000100000000,
		PH_RX_HI  = 14'b00001000000000,
		PH_SP_A   = 14'b00010000000000,
		PH_SP_B   = 14'b00100000000000,
		PH_NK_A   = 14'b01000000000000,
		PH_NK_B   = 14'b10000000000000
	} phase_t;

	typedef struct packed {
		logic [7:0]  device_address;
		logic [7:0]  address_mask;
		logic [15:0] key_read_command;
		logic [7:0]  ack_retry_limit;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  bit_count;
		logic [7:0]  shift_byte;
		logic        byte_index;
		logic [7:0]  retry_left;
		logic [7:0]  data_byte;
		logic        is_read;
		logic [7:0]  received_byte;
		logic        scl;
		logic        sda;
		logic        released;
	} bus_state_t;

	typedef struct packed {
		logic frame_done;
		logic no_ack;
	} step_flags_t;

endpackage

`default_nettype wire

// ===== rtl/tcm_step.sv =====
//------------------------------------------------------------------------------
// tcm_step
// Next-phase logic: advances the bus state by at most one half-bit phase per tick.
//------------------------------------------------------------------------------
`default_nettype none

module tcm_step (
	input  wire tcm_pkg::bus_state_t  cur,
	input  wire tcm_pkg::cfg_t        cfg,
	input  wire logic [1:0]           mode,
	input  wire logic [15:0]          command_word,
	input  wire logic                 sda_level,
	output tcm_pkg::bus_state_t       nxt,
	output tcm_pkg::step_flags_t      flags
);

	logic        begin_read;
	logic [15:0] addr_src;
	logic [7:0]  addr_byte;
	logic [7:0]  rx_byte;

	assign begin_read = (mode == tcm_pkg::MODE_READ);
	assign addr_src   = begin_read ? cfg.key_read_command : command_word;
	assign addr_byte  = (addr_src[14:7] & cfg.address_mask) | cfg.device_address
		| {7'd0, begin_read};
	assign rx_byte    = {cur.shift_byte[6:0], sda_level};

	always_comb begin
		nxt   = cur;
		flags = '0;
		unique case (cur.phase)
			tcm_pkg::PH_IDLE: begin
				if (mode == tcm_pkg::MODE_WRITE || mode == tcm_pkg::MODE_READ) begin
					nxt.is_read    = begin_read;
					nxt.data_byte  = command_word[7:0];
					nxt.shift_byte = addr_byte;
					nxt.byte_index = 1'b0;
					nxt.bit_count  = '0;
					nxt.phase      = tcm_pkg::PH_ST_A;
					{nxt.scl, nxt.sda, nxt.released} = 3'b110;
				end
			end
			tcm_pkg::PH_ST_A: begin
				nxt.phase = tcm_pkg::PH_ST_B;
				{nxt.scl, nxt.sda, nxt.released} = 3'b100;
			end
			tcm_pkg::PH_ST_B: begin
				nxt.phase = tcm_pkg::PH_ST_C;
				{nxt.scl, nxt.sda, nxt.released} = 3'b000;
			end
			tcm_pkg::PH_ST_C: begin
				nxt.bit_count = '0;
				nxt.phase     = tcm_pkg::PH_TX_LO;
				{nxt.scl, nxt.sda, nxt.released} = {1'b0, cur.shift_byte[7], 1'b0};
			end
			tcm_pkg::PH_TX_LO: begin
				nxt.phase = tcm_pkg::PH_TX_HI;
				{nxt.scl, nxt.sda, nxt.released} = {1'b1, cur.shift_byte[7], 1'b0};
			end
			tcm_pkg::PH_TX_HI: begin
				if (cur.bit_count == tcm_pkg::LAST_BIT) begin
					nxt.phase = tcm_pkg::PH_ACK_LO;
					{nxt.scl, nxt.sda, nxt.released} = 3'b011;
				end else begin
					nxt.bit_count  = cur.bit_count + 3'd1;
					nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
					nxt.phase      = tcm_pkg::PH_TX_LO;
					{nxt.scl, nxt.sda, nxt.released} = {1'b0, cur.shift_byte[6], 1'b0};
				end
			end
			tcm_pkg::PH_ACK_LO: begin
				nxt.phase      = tcm_pkg::PH_ACK_HI;
				nxt.retry_left = cfg.ack_retry_limit;
				{nxt.scl, nxt.sda, nxt.released} = 3'b111;
			end
			tcm_pkg::PH_ACK_HI: begin
				priority if (!sda_level) begin
					nxt.bit_count = '0;
					priority if (cur.is_read) begin
						nxt.shift_byte = '0;
						nxt.phase      = tcm_pkg::PH_RX_LO;
						{nxt.scl, nxt.sda, nxt.released} = 3'b011;
					end else if (!cur.byte_index) begin
						nxt.byte_index = 1'b1;
						nxt.shift_byte = cur.data_byte;
						nxt.phase      = tcm_pkg::PH_TX_LO;
						{nxt.scl, nxt.sda, nxt.released} = {1'b0, cur.data_byte[7], 1'b0};
					end else begin
						nxt.phase = tcm_pkg::PH_SP_A;
						{nxt.scl, nxt.sda, nxt.released} = 3'b000;
					end
				end else if (cur.retry_left <= 8'd1) begin
					nxt.retry_left = '0;
					nxt.phase      = tcm_pkg::PH_NK_A;
					{nxt.scl, nxt.sda, nxt.released} = 3'b000;
				end else begin
					nxt.retry_left = cur.retry_left - 8'd1;
				end
			end
			tcm_pkg::PH_RX_LO: begin
				nxt.phase = tcm_pkg::PH_RX_HI;
				{nxt.scl, nxt.sda, nxt.released} = 3'b111;
			end
			tcm_pkg::PH_RX_HI: begin
				nxt.shift_byte = rx_byte;
				if (cur.bit_count == tcm_pkg::LAST_BIT) begin
					nxt.received_byte = rx_byte;
					nxt.phase         = tcm_pkg::PH_SP_A;
					{nxt.scl, nxt.sda, nxt.released} = 3'b000;
				end else begin
					nxt.bit_count = cur.bit_count + 3'd1;
					nxt.phase     = tcm_pkg::PH_RX_LO;
					{nxt.scl, nxt.sda, nxt.released} = 3'b011;
				end
			end
			tcm_pkg::PH_SP_A: begin
				nxt.phase = tcm_pkg::PH_SP_B;
				{nxt.scl, nxt.sda, nxt.released} = 3'b100;
			end
			tcm_pkg::PH_NK_A: begin
				nxt.phase = tcm_pkg::PH_NK_B;
				{nxt.scl, nxt.sda, nxt.released} = 3'b100;
			end
			tcm_pkg::PH_SP_B, tcm_pkg::PH_NK_B: begin
				flags.frame_done = 1'b1;
				flags.no_ack     = (cur.phase == tcm_pkg::PH_NK_B);
				nxt.phase        = tcm_pkg::PH_IDLE;
				{nxt.scl, nxt.sda, nxt.released} = 3'b110;
			end
			default: begin
				nxt.phase = tcm_pkg::PH_IDLE;
				{nxt.scl, nxt.sda, nxt.released} = 3'b110;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/two_wire_command_master.sv =====
//------------------------------------------------------------------------------
// two_wire_command_master
// Two-wire bus master stepped by tick words, at most one half-bit phase per word.
//------------------------------------------------------------------------------
// Each input word advances the bus by at most one phase and yields one result
// word. One word is taken every clock while in_stall is low; each word passes
// through the input register, then the phase logic into the result register.
// in_stall rises only while the input register is full and the
// result register is held by out_stall. Configuration registers sit at byte
// addresses 0, 4, 8 and 12. Device address, address mask and key read command
// take effect on the next frame start; the retry limit on the next ack wait.
`default_nettype none

module two_wire_command_master (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        mode,
	input  wire logic [15:0]                       command_word,
	input  wire logic                              sda_level,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   scl_level,
	output logic                                   sda_drive,
	output logic                                   sda_released,
	output logic                                   busy_res,
	output logic                                   frame_done,
	output logic                                   no_ack,
	output logic [7:0]                             key_code,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [tcm_pkg::CfgAddrWidth-1:0]  paddr,
	input  wire logic [tcm_pkg::CfgDataWidth-1:0]  pwdata,
	output logic [tcm_pkg::CfgDataWidth-1:0]       prdata,
	output logic                                   pready
);

	tcm_pkg::cfg_t        cfg_q;
	tcm_pkg::bus_state_t  state_q;
	tcm_pkg::bus_state_t  state_nxt;
	tcm_pkg::step_flags_t flags;

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [15:0] command_word_s1;
	logic        sda_level_s1;

	logic        out_valid_q;
	logic [13:0] result_q;

	logic out_free;
	logic step_go;
	logic cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign out_free = !out_valid_q || !out_stall;
	assign step_go  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{device_address:   tcm_pkg::RST_DEVICE_ADDRESS,
				address_mask:     tcm_pkg::RST_ADDRESS_MASK,
				key_read_command: tcm_pkg::RST_KEY_READ_COMMAND,
				ack_retry_limit:  tcm_pkg::RST_ACK_RETRY_LIMIT};
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				tcm_pkg::REG_DEVICE_ADDRESS:   cfg_q.device_address   <= pwdata[7:0];
				tcm_pkg::REG_ADDRESS_MASK:     cfg_q.address_mask     <= pwdata[7:0];
				tcm_pkg::REG_KEY_READ_COMMAND: cfg_q.key_read_command <= pwdata[15:0];
				tcm_pkg::REG_ACK_RETRY_LIMIT:  cfg_q.ack_retry_limit  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			tcm_pkg::REG_DEVICE_ADDRESS:   prdata = {24'd0, cfg_q.device_address};
			tcm_pkg::REG_ADDRESS_MASK:     prdata = {24'd0, cfg_q.address_mask};
			tcm_pkg::REG_KEY_READ_COMMAND: prdata = {16'd0, cfg_q.key_read_command};
			tcm_pkg::REG_ACK_RETRY_LIMIT:  prdata = {24'd0, cfg_q.ack_retry_limit};
			default:                       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			mode_s1         <= mode;
			command_word_s1 <= command_word;
			sda_level_s1    <= sda_level;
		end
	end

	tcm_step u_step (
		.cur          (state_q),
		.cfg          (cfg_q),
		.mode         (mode_s1),
		.command_word (command_word_s1),
		.sda_level    (sda_level_s1),
		.nxt          (state_nxt),
		.flags        (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: tcm_pkg::PH_IDLE, bit_count: 3'd0, shift_byte: 8'd0,
				byte_index: 1'b0, retry_left: 8'd0, data_byte: 8'd0, is_read: 1'b0,
				received_byte: 8'd0, scl: 1'b1, sda: 1'b1, released: 1'b0};
		end else if (step_go) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			result_q <= {state_nxt.scl, state_nxt.sda, state_nxt.released,
				state_nxt.phase != tcm_pkg::PH_IDLE, flags.frame_done, flags.no_ack,
				state_nxt.received_byte};
		end
	end

	assign out_valid    = out_valid_q;
	assign scl_level    = result_q[13];
	assign sda_drive    = result_q[12];
	assign sda_released = result_q[11];
	assign busy_res     = result_q[10];
	assign frame_done   = result_q[9];
	assign no_ack       = result_q[8];
	assign key_code     = result_q[7:0];

endmodule

`default_nettype wire

// ===== dv/two_wire_command_master_checker.sv =====
//------------------------------------------------------------------------------
// two_wire_command_master_checker
// Watches the word channels and the register port and checks every result word.
//------------------------------------------------------------------------------
// Each input word accepted by the block steps a local copy of the bus phase
// machine; the predicted result word is queued and compared field by field
// with the next result word the block hands over. Register writes seen on the
// configuration port update the local copy of the registers.

module two_wire_command_master_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic [1:0]                        mode,
	input  wire logic [15:0]                       command_word,
	input  wire logic                              sda_level,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic                              scl_level,
	input  wire logic                              sda_drive,
	input  wire logic                              sda_released,
	input  wire logic                              busy_res,
	input  wire logic                              frame_done,
	input  wire logic                              no_ack,
	input  wire logic [7:0]                        key_code,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic                              pready,
	input  wire logic [tcm_pkg::CfgAddrWidth-1:0]  paddr,
	input  wire logic [tcm_pkg::CfgDataWidth-1:0]  pwdata,
	output int unsigned                            failures,
	output int unsigned                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       released;
		logic       busy;
		logic       done;
		logic       nak;
		logic [7:0] key;
	} bus_word_t;

	logic [7:0]  dev_addr;
	logic [7:0]  addr_mask;
	logic [15:0] key_cmd;
	logic [7:0]  retry_limit;

	tcm_pkg::phase_t phase;
	logic [2:0]  bit_cnt;
	logic [7:0]  shreg;
	logic        second_byte;
	logic [7:0]  retries;
	logic [15:0] held_cmd;
	logic        reading;
	logic [7:0]  key_byte;
	logic        scl_q;
	logic        sda_q;
	logic        rel_q;

	bus_word_t   bus_words_due[$];
	int unsigned fail_count;
	int unsigned words_checked;

	function automatic bus_word_t next_bus_word(input logic [1:0] m, input logic [15:0] cmd,
			input logic sda);
		logic done;
		logic nak;
		done = 1'b0;
		nak  = 1'b0;
		case (phase)
			tcm_pkg::PH_IDLE: begin
				if (m == tcm_pkg::MODE_WRITE || m == tcm_pkg::MODE_READ) begin
					reading     = (m == tcm_pkg::MODE_READ);
					held_cmd    = reading ? key_cmd : cmd;
					shreg       = (held_cmd[14:7] & addr_mask) | dev_addr | {7'd0, reading};
					second_byte = 1'b0;
					bit_cnt     = '0;
					phase       = tcm_pkg::PH_ST_A;
					{scl_q, sda_q, rel_q} = 3'b110;
				end
			end
			tcm_pkg::PH_ST_A: begin
				phase = tcm_pkg::PH_ST_B;
				{scl_q, sda_q, rel_q} = 3'b100;
			end
			tcm_pkg::PH_ST_B: begin
				phase = tcm_pkg::PH_ST_C;
				{scl_q, sda_q, rel_q} = 3'b000;
			end
			tcm_pkg::PH_ST_C: begin
				bit_cnt = '0;
				phase   = tcm_pkg::PH_TX_LO;
				{scl_q, sda_q, rel_q} = {1'b0, shreg[7], 1'b0};
			end
			tcm_pkg::PH_TX_LO: begin
				phase = tcm_pkg::PH_TX_HI;
				{scl_q, sda_q, rel_q} = {1'b1, shreg[7], 1'b0};
			end
			tcm_pkg::PH_TX_HI: begin
				if (bit_cnt == tcm_pkg::LAST_BIT) begin
					phase = tcm_pkg::PH_ACK_LO;
					{scl_q, sda_q, rel_q} = 3'b011;
				end else begin
					bit_cnt = bit_cnt + 3'd1;
					shreg   = {shreg[6:0], 1'b0};
					phase   = tcm_pkg::PH_TX_LO;
					{scl_q, sda_q, rel_q} = {1'b0, shreg[7], 1'b0};
				end
			end
			tcm_pkg::PH_ACK_LO: begin
				phase   = tcm_pkg::PH_ACK_HI;
				retries = retry_limit;
				{scl_q, sda_q, rel_q} = 3'b111;
			end
			tcm_pkg::PH_ACK_HI: begin
				if (!sda) begin
					bit_cnt = '0;
					if (reading) begin
						shreg = '0;
						phase = tcm_pkg::PH_RX_LO;
						{scl_q, sda_q, rel_q} = 3'b011;
					end else if (!second_byte) begin
						second_byte = 1'b1;
						shreg       = held_cmd[7:0];
						phase       = tcm_pkg::PH_TX_LO;
						{scl_q, sda_q, rel_q} = {1'b0, shreg[7], 1'b0};
					end else begin
						phase = tcm_pkg::PH_SP_A;
						{scl_q, sda_q, rel_q} = 3'b000;
					end
				end else if (retries <= 8'd1) begin
					retries = '0;
					phase   = tcm_pkg::PH_NK_A;
					{scl_q, sda_q, rel_q} = 3'b000;
				end else begin
					retries = retries - 8'd1;
				end
			end
			tcm_pkg::PH_RX_LO: begin
				phase = tcm_pkg::PH_RX_HI;
				{scl_q, sda_q, rel_q} = 3'b111;
			end
			tcm_pkg::PH_RX_HI: begin
				shreg = {shreg[6:0], sda};
				if (bit_cnt == tcm_pkg::LAST_BIT) begin
					key_byte = shreg;
					phase    = tcm_pkg::PH_SP_A;
					{scl_q, sda_q, rel_q} = 3'b000;
				end else begin
					bit_cnt = bit_cnt + 3'd1;
					phase   = tcm_pkg::PH_RX_LO;
					{scl_q, sda_q, rel_q} = 3'b011;
				end
			end
			tcm_pkg::PH_SP_A: begin
				phase = tcm_pkg::PH_SP_B;
				{scl_q, sda_q, rel_q} = 3'b100;
			end
			tcm_pkg::PH_NK_A: begin
				phase = tcm_pkg::PH_NK_B;
				{scl_q, sda_q, rel_q} = 3'b100;
			end
			tcm_pkg::PH_SP_B, tcm_pkg::PH_NK_B: begin
				nak   = (phase == tcm_pkg::PH_NK_B);
				done  = 1'b1;
				phase = tcm_pkg::PH_IDLE;
				{scl_q, sda_q, rel_q} = 3'b110;
			end
			default: begin
				phase = tcm_pkg::PH_IDLE;
				{scl_q, sda_q, rel_q} = 3'b110;
			end
		endcase
		return {scl_q, sda_q, rel_q, phase != tcm_pkg::PH_IDLE, done, nak, key_byte};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_word_t due;
		bus_word_t got;
		if (!arst_n) begin
			dev_addr    = tcm_pkg::RST_DEVICE_ADDRESS;
			addr_mask   = tcm_pkg::RST_ADDRESS_MASK;
			key_cmd     = tcm_pkg::RST_KEY_READ_COMMAND;
			retry_limit = tcm_pkg::RST_ACK_RETRY_LIMIT;
			phase       = tcm_pkg::PH_IDLE;
			bit_cnt     = '0;
			shreg       = '0;
			second_byte = 1'b0;
			retries     = '0;
			held_cmd    = '0;
			reading     = 1'b0;
			key_byte    = '0;
			{scl_q, sda_q, rel_q} = 3'b110;
			bus_words_due.delete();
			fail_count    = 0;
			words_checked = 0;
			failures    <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {scl_level, sda_drive, sda_released, busy_res, frame_done, no_ack,
					key_code};
				if (bus_words_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t: result word %0d with no word outstanding", $realtime,
							words_checked);
				end else begin
					due = bus_words_due.pop_front();
					if (got !== due) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("%t: word %0d exp/got scl %b/%b sda %b/%b rel %b/%b",
								$realtime, words_checked, due.scl, got.scl, due.sda, got.sda,
								due.released, got.released);
							$display(" busy %b/%b done %b/%b nak %b/%b key %h/%h",
								due.busy, got.busy, due.done, got.done, due.nak, got.nak,
								due.key, got.key);
						end
					end
				end
				words_checked++;
			end
			if (in_valid && !in_stall)
				bus_words_due.push_back(next_bus_word(mode, command_word, sda_level));
			if (psel && penable && pwrite && pready) begin
				case (paddr[tcm_pkg::CfgAddrWidth-1:2])
					tcm_pkg::REG_DEVICE_ADDRESS:   dev_addr    = pwdata[7:0];
					tcm_pkg::REG_ADDRESS_MASK:     addr_mask   = pwdata[7:0];
					tcm_pkg::REG_KEY_READ_COMMAND: key_cmd     = pwdata[15:0];
					tcm_pkg::REG_ACK_RETRY_LIMIT:  retry_limit = pwdata[7:0];
					default: ;
				endcase
			end
			failures    <= fail_count;
			outstanding <= bus_words_due.size();
		end
	end

endmodule

// ===== dv/two_wire_command_master_test.sv =====
//------------------------------------------------------------------------------
// two_wire_command_master_test
// Drives bus frames into the two-wire command master and gives the verdict.
//------------------------------------------------------------------------------
// A short directed run covers idle ticks, write and read frames, late acks,
// ack timeouts on either byte and frame starts while busy. Random segments
// then follow under several register settings, mostly well-formed frames with
// random content, some idle words and some broken sequences. Sender gaps and
// receiver stalls change between segments, and one long receiver hold-off
// backs the block up. Checking is done by the checker instance.

module two_wire_command_master_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned HOLD_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = tcm_pkg::MODE_TICK;
	logic [15:0] command_word = '0;
	logic        sda_level = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        scl_level;
	logic        sda_drive;
	logic        sda_released;
	logic        busy_res;
	logic        frame_done;
	logic        no_ack;
	logic [7:0]  key_code;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [tcm_pkg::CfgAddrWidth-1:0] paddr = '0;
	logic [tcm_pkg::CfgDataWidth-1:0] pwdata = '0;
	logic [tcm_pkg::CfgDataWidth-1:0] prdata;
	logic        pready;

	int unsigned failures;
	int unsigned outstanding;
	int unsigned cycles = 0;
	int unsigned words_sent = 0;
	int unsigned send_gap_pct = 28;
	int unsigned recv_stall_pct = 73;
	int unsigned hold_left = 0;
	bit          hold_go = 1'b0;
	bit          hold_seen = 1'b0;
	logic [7:0]  ack_limit = tcm_pkg::RST_ACK_RETRY_LIMIT;

	two_wire_command_master u_top (
		.clk, .arst_n, .in_valid, .in_stall, .mode, .command_word, .sda_level,
		.out_valid, .out_stall, .scl_level, .sda_drive, .sda_released, .busy_res,
		.frame_done, .no_ack, .key_code, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready
	);

	two_wire_command_master_checker u_checker (
		.clk, .arst_n, .in_valid, .in_stall, .mode, .command_word, .sda_level,
		.out_valid, .out_stall, .scl_level, .sda_drive, .sda_released, .busy_res,
		.frame_done, .no_ack, .key_code, .psel, .penable, .pwrite, .pready, .paddr,
		.pwdata, .failures, .outstanding
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_word(input logic [1:0] m, input logic [15:0] cmd, input logic sda);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		command_word <= cmd;
		sda_level    <= sda;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// ignored modes inside a frame; noisy frames try to begin while busy
	task automatic frame_tick(input bit noisy, input logic sda);
		logic [1:0] m;
		if (noisy)
			m = 2'($urandom_range(1, 3));
		else if ($urandom_range(9) == 0)
			m = 2'($urandom_range(3));
		else
			m = tcm_pkg::MODE_TICK;
		send_word(m, 16'($urandom), sda);
	endtask

	task automatic ack_wait(input int highs, input int lim, input bit noisy, output bit acked);
		acked = (highs < lim);
		repeat (acked ? highs : lim) frame_tick(noisy, 1'b1);
		if (acked)
			frame_tick(noisy, 1'b0);
	endtask

	task automatic run_frame(input logic rd, input logic [15:0] cmd, input int highs_a,
			input int highs_b, input logic [7:0] rx, input bit noisy);
		int lim;
		bit acked;
		lim = (ack_limit == 0) ? 1 : ack_limit;
		send_word(rd ? tcm_pkg::MODE_READ : tcm_pkg::MODE_WRITE, cmd, 1'($urandom));
		repeat (20) frame_tick(noisy, 1'($urandom));
		ack_wait(highs_a, lim, noisy, acked);
		if (acked) begin
			if (rd) begin
				for (int i = 7; i >= 0; i--) begin
					frame_tick(noisy, 1'($urandom));
					frame_tick(noisy, rx[i]);
				end
			end else begin
				repeat (17) frame_tick(noisy, 1'($urandom));
				ack_wait(highs_b, lim, noisy, acked);
			end
		end
		repeat (2) frame_tick(noisy, 1'($urandom));
	endtask

	function automatic int pick_highs();
		int r;
		r = $urandom_range(9);
		if (r < 6)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(ack_limit + 2);
	endfunction

	task automatic drain_words();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx,
			input logic [tcm_pkg::CfgDataWidth-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_config(input logic [7:0] dev, input logic [7:0] msk,
			input logic [15:0] key, input logic [7:0] lim);
		drain_words();
		write_reg(tcm_pkg::REG_DEVICE_ADDRESS, {24'($urandom), dev});
		write_reg(tcm_pkg::REG_ADDRESS_MASK, {24'($urandom), msk});
		write_reg(tcm_pkg::REG_KEY_READ_COMMAND, {16'($urandom), key});
		write_reg(tcm_pkg::REG_ACK_RETRY_LIMIT, {24'($urandom), lim});
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		ack_limit  = lim;
	endtask

	task automatic random_segment(input int unsigned count);
		int unsigned target;
		int r;
		target = words_sent + count;
		while (words_sent < target) begin
			r = $urandom_range(99);
			if (r < 85) begin
				run_frame(1'($urandom), 16'($urandom), pick_highs(), pick_highs(),
					8'($urandom), $urandom_range(9) == 0);
			end else if (r < 93) begin
				repeat ($urandom_range(1, 4))
					send_word($urandom_range(1) ? tcm_pkg::MODE_TICK : MODE_UNUSED,
						16'($urandom), 1'($urandom));
			end else begin
				repeat ($urandom_range(1, 30))
					send_word(2'($urandom), 16'($urandom), 1'($urandom));
				// flush whatever frame got started
				repeat (45) send_word(tcm_pkg::MODE_TICK, 16'($urandom), 1'b0);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(MODE_UNUSED, 16'hFFFF, 1'b1);
		send_word(tcm_pkg::MODE_TICK, 16'h0000, 1'b0);
		run_frame(1'b0, 16'hFFFF, 0, 0, 8'h00, 1'b0);
		run_frame(1'b0, 16'h0000, 3, 1, 8'h00, 1'b0);
		run_frame(1'b0, 16'h8055, 0, 20, 8'h00, 1'b0);
		run_frame(1'b0, 16'h7FAA, 25, 0, 8'h00, 1'b0);
		run_frame(1'b1, 16'h0000, 0, 0, 8'hFF, 1'b0);
		run_frame(1'b1, 16'hFFFF, 19, 0, 8'h00, 1'b1);
		run_frame(1'b1, 16'h0000, 0, 0, 8'hA5, 1'b0);
		run_frame(1'b1, 16'h0000, 20, 0, 8'h00, 1'b0);
		send_word(MODE_UNUSED, 16'h0000, 1'b0);

		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0: set_config(8'h00, 8'hFF, 16'hFFFF, 8'd1);
				1: set_config(8'hFF, 8'h00, 16'h0000, 8'd255);
				2: set_config(8'($urandom), 8'($urandom), 16'($urandom), 8'd0);
				default: set_config(8'($urandom), 8'($urandom), 16'($urandom),
					8'($urandom_range(1, 12)));
			endcase
			case (seg / 2)
				0: begin
					send_gap_pct    = 28;
					recv_stall_pct <= 73;
				end
				1: begin
					send_gap_pct    = 73;
					recv_stall_pct <= 28;
				end
				default: begin
					send_gap_pct    = 0;
					recv_stall_pct <= 0;
				end
			endcase
			if (seg == 4)
				hold_go <= ~hold_go;
			random_segment(210);
		end

		drain_words();
		repeat (8) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tcm_pkg.sv
rtl/tcm_step.sv
rtl/two_wire_command_master.sv
dv/two_wire_command_master_checker.sv
dv/two_wire_command_master_test.sv
